[design/rfca_pkg.sv]
// Shared types and constants for the RF code alarm arming controller.
// Used by every module of the block; depends on nothing else.

package rfca_pkg;

  localparam int TimeW    = 32;
  localparam int CodeW    = 32;
  localparam int NumCodes = 6;
  localparam int KindW    = $clog2(NumCodes);
  localparam int NumRegs  = 8;
  localparam int RegIdxW  = $clog2(NumRegs);

  // Configuration register indexes.
  typedef enum logic [RegIdxW-1:0] {
    REG_CODE_ON_FIRST    = 3'd0,
    REG_CODE_ON_SECOND   = 3'd1,
    REG_CODE_OFF_FIRST   = 3'd2,
    REG_CODE_OFF_SECOND  = 3'd3,
    REG_CODE_DOOR        = 3'd4,
    REG_CODE_MOTION      = 3'd5,
    REG_ARMING_DELAY_MS  = 3'd6,
    REG_REPEAT_WINDOW_MS = 3'd7
  } reg_idx_t;

  // Code kinds in match priority order; also the stamp memory address.
  typedef enum logic [KindW-1:0] {
    KIND_ON_FIRST   = 3'd0,
    KIND_ON_SECOND  = 3'd1,
    KIND_OFF_FIRST  = 3'd2,
    KIND_OFF_SECOND = 3'd3,
    KIND_DOOR       = 3'd4,
    KIND_MOTION     = 3'd5
  } kind_t;

  typedef struct packed {
    logic [NumCodes-1:0][CodeW-1:0] codes;
    logic [TimeW-1:0]               arming_delay_ms;
    logic [TimeW-1:0]               repeat_window_ms;
  } cfg_t;

  typedef struct packed {
    logic  hit;
    kind_t kind;
  } match_t;

  typedef struct packed {
    logic             en;
    kind_t            addr;
    logic [TimeW-1:0] data;
  } stamp_wr_t;

  // Packed so that armed lands in the lowest bit.
  typedef struct packed {
    logic motion_alarm;
    logic door_alarm;
    logic off_sound;
    logic arming_sound;
    logic armed;
  } result_t;

  localparam int ResultW = $bits(result_t);
  localparam int OutDataW = ((ResultW + 7) / 8) * 8;

endpackage

[design/rf_code_alarm_arming_controller.sv]
// RF code alarm arming controller, top level.
// A poll is registered in the evaluation stage, and its result then in the output register;
// one poll per cycle while the output is not stalled, bounded by the stamp memory
// read-modify-write, with same-entry overlap resolved by write-to-read forwarding.
// Reset (rst_n low, synchronous): disarmed, arm time zero, config zero, stamp
// valid bits cleared so every stamp reads as zero; no clearing pass is needed.

module rf_code_alarm_arming_controller (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,   // now_ms[31:0], rx_code[63:32]
  input  logic        in_tuser,   // code_valid[0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // armed[0], arming_sound[1], off_sound[2],
                                  // door_alarm[3], motion_alarm[4], zero[7:5]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rfca_pkg::cfg_t                   cfg;
  rfca_pkg::match_t                 match;
  rfca_pkg::stamp_wr_t              stamp_wr;
  rfca_pkg::result_t                result;
  logic [rfca_pkg::TimeW-1:0]       stamp;
  logic                             in_fire;

  rfca_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .code_valid (in_tuser),
    .rx_code    (in_tdata[63:32]),
    .cfg        (cfg),
    .match      (match)
  );

  rfca_stamp_ram u_stamp_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_en   (in_fire && match.hit),
    .rd_addr (match.kind),
    .rd_data (stamp),
    .wr      (stamp_wr)
  );

  rfca_eval u_eval (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_fire   (in_fire),
    .now_ms    (in_tdata[31:0]),
    .match     (match),
    .stamp     (stamp),
    .stamp_wr  (stamp_wr),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .result    (result)
  );

  assign out_tdata = {(rfca_pkg::OutDataW - rfca_pkg::ResultW)'(0), result};

endmodule

[design/rfca_cfg.sv]
// Configuration register file and priority code matcher.
// Depends on rfca_pkg.

module rfca_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [rfca_pkg::RegIdxW-1:0]  cfg_index,
  input  logic [31:0]                   cfg_data,
  input  logic                          code_valid,
  input  logic [rfca_pkg::CodeW-1:0]    rx_code,
  output rfca_pkg::cfg_t                cfg,
  output rfca_pkg::match_t              match
);

  rfca_pkg::cfg_t cfg_r;
  rfca_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (rfca_pkg::reg_idx_t'(cfg_index))
        rfca_pkg::REG_CODE_ON_FIRST:    cfg_nxt.codes[rfca_pkg::KIND_ON_FIRST]   = cfg_data;
        rfca_pkg::REG_CODE_ON_SECOND:   cfg_nxt.codes[rfca_pkg::KIND_ON_SECOND]  = cfg_data;
        rfca_pkg::REG_CODE_OFF_FIRST:   cfg_nxt.codes[rfca_pkg::KIND_OFF_FIRST]  = cfg_data;
        rfca_pkg::REG_CODE_OFF_SECOND:  cfg_nxt.codes[rfca_pkg::KIND_OFF_SECOND] = cfg_data;
        rfca_pkg::REG_CODE_DOOR:        cfg_nxt.codes[rfca_pkg::KIND_DOOR]       = cfg_data;
        rfca_pkg::REG_CODE_MOTION:      cfg_nxt.codes[rfca_pkg::KIND_MOTION]     = cfg_data;
        rfca_pkg::REG_ARMING_DELAY_MS:  cfg_nxt.arming_delay_ms  = cfg_data;
        rfca_pkg::REG_REPEAT_WINDOW_MS: cfg_nxt.repeat_window_ms = cfg_data;
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Walk from the lowest priority up so that the first match wins.
  always_comb begin
    match.hit  = 1'b0;
    match.kind = rfca_pkg::KIND_ON_FIRST;
    for (int i = rfca_pkg::NumCodes - 1; i >= 0; i--) begin
      if (code_valid && (rx_code == cfg_r.codes[i])) begin
        match.hit  = 1'b1;
        match.kind = rfca_pkg::kind_t'(3'(i));
      end
    end
  end

endmodule

[design/rfca_stamp_ram.sv]
// Six-entry acceptance time memory with a registered read port, per-entry
// valid bits that read as zero after reset, and write-to-read forwarding.
// Depends on rfca_pkg.

module rfca_stamp_ram (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        rd_en,
  input  rfca_pkg::kind_t             rd_addr,
  output logic [rfca_pkg::TimeW-1:0]  rd_data,
  input  rfca_pkg::stamp_wr_t         wr
);

  logic [rfca_pkg::TimeW-1:0]    mem [rfca_pkg::NumCodes];
  logic [rfca_pkg::NumCodes-1:0] vld_r;
  logic [rfca_pkg::NumCodes-1:0] vld_nxt;
  logic [rfca_pkg::TimeW-1:0]    rd_data_r;
  logic                          rd_hit;

  assign rd_data = rd_data_r;
  assign rd_hit  = wr.en && (wr.addr == rd_addr);

  always_comb begin
    vld_nxt = vld_r;
    if (wr.en && (int'(wr.addr) < rfca_pkg::NumCodes)) begin
      vld_nxt[wr.addr] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && (int'(wr.addr) < rfca_pkg::NumCodes)) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // A write landing on the same edge as the read is forwarded to the reader.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      if (rd_hit) begin
        rd_data_r <= wr.data;
      end else if ((int'(rd_addr) < rfca_pkg::NumCodes) && vld_r[rd_addr]) begin
        rd_data_r <= mem[rd_addr];
      end else begin
        rd_data_r <= '0;
      end
    end
  end

  a_forward: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && rd_hit) |=> (rd_data_r == $past(wr.data)))
    else $error("stamp read missed a same-edge write");

  a_unwritten_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (rd_en && !rd_hit && (int'(rd_addr) < rfca_pkg::NumCodes) && !vld_r[rd_addr])
      |=> (rd_data_r == '0))
    else $error("unwritten stamp did not read as zero");

  a_read_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !rd_en |=> $stable(rd_data_r))
    else $error("stamp read data changed without a read");

endmodule

[design/rfca_eval.sv]
// Evaluation stage: repeat-window check against the stamp read, arming state
// update, stamp write-back and the registered result.
// Depends on rfca_pkg.

module rfca_eval (
  input  logic                        clk,
  input  logic                        rst_n,
  input  rfca_pkg::cfg_t              cfg,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  output logic                        in_fire,
  input  logic [rfca_pkg::TimeW-1:0]  now_ms,
  input  rfca_pkg::match_t            match,
  input  logic [rfca_pkg::TimeW-1:0]  stamp,
  output rfca_pkg::stamp_wr_t         stamp_wr,
  output logic                        out_valid,
  input  logic                        out_ready,
  output rfca_pkg::result_t           result
);

  logic                       s1_valid_r, s1_valid_nxt;
  logic [rfca_pkg::TimeW-1:0] s1_now_r;
  rfca_pkg::match_t           s1_match_r;
  logic                       s1_fire;

  logic                       armed_r, armed_nxt;
  logic [rfca_pkg::TimeW-1:0] arm_start_r, arm_start_nxt;

  logic                       out_valid_r, out_valid_nxt;
  rfca_pkg::result_t          out_res_r, res_nxt;

  logic [rfca_pkg::TimeW-1:0] since_arm;
  logic [rfca_pkg::TimeW-1:0] since_stamp;
  logic                       within_delay;
  logic                       fresh;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_tready = !s1_valid_r || s1_fire;
  assign in_fire   = in_tvalid && in_tready;
  assign out_valid = out_valid_r;
  assign result    = out_res_r;

  assign since_arm    = s1_now_r - arm_start_r;
  assign since_stamp  = s1_now_r - stamp;
  assign within_delay = since_arm <= cfg.arming_delay_ms;
  assign fresh        = s1_match_r.hit && (since_stamp > cfg.repeat_window_ms);

  always_comb begin
    armed_nxt     = armed_r;
    arm_start_nxt = arm_start_r;
    res_nxt       = '0;
    stamp_wr.en   = 1'b0;
    stamp_wr.addr = s1_match_r.kind;
    stamp_wr.data = s1_now_r;
    res_nxt.arming_sound = armed_r && within_delay;
    if (s1_fire && fresh) begin
      stamp_wr.en = 1'b1;
      case (s1_match_r.kind)
        rfca_pkg::KIND_ON_FIRST, rfca_pkg::KIND_ON_SECOND: begin
          armed_nxt     = 1'b1;
          arm_start_nxt = s1_now_r;
        end
        rfca_pkg::KIND_OFF_FIRST, rfca_pkg::KIND_OFF_SECOND: begin
          armed_nxt         = 1'b0;
          res_nxt.off_sound = 1'b1;
        end
        rfca_pkg::KIND_DOOR: begin
          res_nxt.door_alarm = armed_r && !within_delay;
        end
        rfca_pkg::KIND_MOTION: begin
          res_nxt.motion_alarm = armed_r && !within_delay;
        end
        default: begin
          stamp_wr.en = 1'b0;
        end
      endcase
    end
    res_nxt.armed = armed_nxt;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (s1_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      armed_r     <= 1'b0;
      arm_start_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (s1_fire) begin
        armed_r     <= armed_nxt;
        arm_start_r <= arm_start_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_now_r   <= now_ms;
      s1_match_r <= match;
    end
    if (s1_fire) begin
      out_res_r <= res_nxt;
    end
  end

  a_off_disarms: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_res_r.off_sound) |-> !out_res_r.armed)
    else $error("off sound reported while still armed");

  a_one_alarm: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(out_res_r.door_alarm && out_res_r.motion_alarm))
    else $error("door and motion alarm raised by one poll");

  a_arm_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (stamp_wr.en && ((s1_match_r.kind == rfca_pkg::KIND_ON_FIRST) ||
                     (s1_match_r.kind == rfca_pkg::KIND_ON_SECOND)))
      |=> (armed_r && (arm_start_r == $past(s1_now_r))))
    else $error("accepted arm code did not restart the arming time");

endmodule
